// ===== src/tmrb_pkg.sv =====
// Shared types and constants of the one-shot/periodic timer bank.
// No dependencies; imported by the top level and the countdown unit.
package tmrb_pkg;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned NW          = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] ACT_ADD_ONESHOT  = 2'd0;
  localparam logic [1:0] ACT_ADD_PERIODIC = 2'd1;
  localparam logic [1:0] ACT_TICK         = 2'd2;

  localparam logic RES_ADD_ACK = 1'b0;
  localparam logic RES_FIRED   = 1'b1;

  typedef logic signed [32:0] cnt_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] handle;
    logic [31:0] delay_ms;
    logic [15:0] delta_ms;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] fired_handle;
    logic        from_periodic;
    logic        table_full;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [15:0] handle;
    cnt_t        rem;
  } os_entry_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] reload;
    cnt_t        rem;
  } pr_entry_t;

endpackage

// ===== src/oneshot_periodic_timer_bank.sv =====
// Bank of one-shot and periodic countdown timers with a shared countdown unit.
// Add: accepted in idle, acknowledged from the add state once the output register is free (1 result, last set).
// Tick: one slot per cycle through the single subtract/compare unit and table
//   read port, held while the output register cannot take a reported fire.
// Inputs are taken only in idle; one item is worked on at a time.
// Reset clears fill counts and the sequencer; table contents are undefined.
module oneshot_periodic_timer_bank #(
  parameter int unsigned ONESHOT_SLOTS  = 16,
  parameter int unsigned PERIODIC_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tmrb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tmrb_pkg::out_t out_data_o
);
  import tmrb_pkg::*;

  localparam int unsigned OIW  = (ONESHOT_SLOTS > 1) ? $clog2(ONESHOT_SLOTS) : 1;
  localparam int unsigned PIW  = (PERIODIC_SLOTS > 1) ? $clog2(PERIODIC_SLOTS) : 1;
  localparam int unsigned OCW  = $clog2(ONESHOT_SLOTS + 1);
  localparam int unsigned PCW  = $clog2(PERIODIC_SLOTS + 1);
  localparam int unsigned MAXS = (ONESHOT_SLOTS > PERIODIC_SLOTS) ? ONESHOT_SLOTS
                                                                  : PERIODIC_SLOTS;
  localparam int unsigned ICW  = $clog2(MAXS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_OS_RD,
    S_OS_ACT,
    S_PR_RD,
    S_PR_ACT,
    S_FLUSH
  } state_e;

  // Sequencer and bookkeeping registers.
  state_e         state_q, state_d;
  in_t            item_q, item_d;
  logic [ICW-1:0] i_q, i_d;          // slot being scanned
  logic [OCW-1:0] w_q, w_d;          // compaction write slot of the one-shot table
  logic [OCW-1:0] os_used_q, os_used_d;
  logic [PCW-1:0] pr_used_q, pr_used_d;
  logic [NW-1:0]  n_q, n_d;          // fires reported on this tick, pending one included
  logic           pend_v_q, pend_v_d;
  logic [15:0]    pend_handle_q, pend_handle_d;
  logic           pend_per_q, pend_per_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_data_q, out_data_d;

  // Table ports.
  logic           os_we, pr_we;
  logic [OIW-1:0] os_waddr, os_raddr;
  logic [PIW-1:0] pr_waddr, pr_raddr;
  os_entry_t      os_wdata, os_rd;
  pr_entry_t      pr_wdata, pr_rd;

  // Shared countdown unit.
  cnt_t           alu_rem, alu_cnt;
  logic           alu_fire;

  logic           out_free;
  logic           stall_scan;
  logic           adv;
  logic [ICW-1:0] i_nxt;
  logic           add_per, add_full;

  tmrb_ram #(
    .DEPTH (ONESHOT_SLOTS),
    .WIDTH ($bits(os_entry_t))
  ) u_os_ram (
    .clk_i   (clk_i),
    .we_i    (os_we),
    .waddr_i (os_waddr),
    .wdata_i (os_wdata),
    .raddr_i (os_raddr),
    .rdata_o (os_rd)
  );

  tmrb_ram #(
    .DEPTH (PERIODIC_SLOTS),
    .WIDTH ($bits(pr_entry_t))
  ) u_pr_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_waddr),
    .wdata_i (pr_wdata),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rd)
  );

  // One unit serves both tables; the scan state picks the operand.
  assign alu_rem = (state_q == S_PR_ACT) ? pr_rd.rem : os_rd.rem;

  tmrb_alu u_alu (
    .rem_i   (alu_rem),
    .delta_i (item_q.delta_ms),
    .cnt_o   (alu_cnt),
    .fire_o  (alu_fire)
  );

  // The output register takes a new result when empty or when its transfer completes.
  assign out_free = !out_valid_q || !out_stall_i;

  // A reported fire must push the previous pending one out; hold the scan
  // when the output register cannot take it.
  assign stall_scan = alu_fire && (n_q < NW'(MAX_RESULTS)) && pend_v_q && !out_free;
  assign adv        = !stall_scan;
  assign i_nxt      = i_q + 1'b1;

  assign add_per  = (item_q.action == ACT_ADD_PERIODIC);
  assign add_full = add_per ? (pr_used_q == PCW'(PERIODIC_SLOTS))
                            : (os_used_q == OCW'(ONESHOT_SLOTS));

  // Read addresses: slot 0 before a scan, then the next slot once this one retires.
  assign os_raddr = (state_q == S_OS_ACT) ? OIW'(adv ? i_nxt : i_q) : '0;
  assign pr_raddr = (state_q == S_PR_ACT) ? PIW'(adv ? i_nxt : i_q) : '0;

  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    i_d           = i_q;
    w_d           = w_q;
    os_used_d     = os_used_q;
    pr_used_d     = pr_used_q;
    n_d           = n_q;
    pend_v_d      = pend_v_q;
    pend_handle_d = pend_handle_q;
    pend_per_d    = pend_per_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_data_d    = out_data_q;

    os_we           = 1'b0;
    os_waddr        = w_q[OIW-1:0];
    os_wdata.handle = os_rd.handle;
    os_wdata.rem    = alu_cnt;
    pr_we           = 1'b0;
    pr_waddr        = i_q[PIW-1:0];
    pr_wdata.handle = pr_rd.handle;
    pr_wdata.reload = pr_rd.reload;
    pr_wdata.rem    = alu_fire ? $signed({1'b0, pr_rd.reload}) : alu_cnt;

    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          unique case (in_data_i.action) inside
            ACT_ADD_ONESHOT, ACT_ADD_PERIODIC: begin
              state_d = S_ADD;
            end
            ACT_TICK: begin
              i_d      = '0;
              w_d      = '0;
              n_d      = '0;
              pend_v_d = 1'b0;
              state_d  = S_OS_RD;
            end
            default: begin
              // Unused action: drop it, no result.
            end
          endcase
        end
      end

      S_ADD: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.result_kind     = RES_ADD_ACK;
          out_data_d.fired_handle    = item_q.handle;
          out_data_d.from_periodic   = add_per;
          out_data_d.table_full      = add_full;
          out_data_d.last            = 1'b1;
          if (!add_full) begin
            if (add_per) begin
              pr_we           = 1'b1;
              pr_waddr        = pr_used_q[PIW-1:0];
              pr_wdata.handle = item_q.handle;
              pr_wdata.reload = item_q.delay_ms;
              pr_wdata.rem    = $signed({1'b0, item_q.delay_ms});
              pr_used_d       = pr_used_q + 1'b1;
            end else begin
              os_we           = 1'b1;
              os_waddr        = os_used_q[OIW-1:0];
              os_wdata.handle = item_q.handle;
              os_wdata.rem    = $signed({1'b0, item_q.delay_ms});
              os_used_d       = os_used_q + 1'b1;
            end
          end
          state_d = S_IDLE;
        end
      end

      S_OS_RD: begin
        state_d = (os_used_q == '0) ? S_PR_RD : S_OS_ACT;
      end

      S_PR_RD: begin
        state_d = (pr_used_q == '0) ? S_FLUSH : S_PR_ACT;
      end

      S_OS_ACT, S_PR_ACT: begin
        if (adv) begin
          if (alu_fire) begin
            if (n_q < NW'(MAX_RESULTS)) begin
              if (pend_v_q) begin
                out_valid_d              = 1'b1;
                out_data_d.result_kind   = RES_FIRED;
                out_data_d.fired_handle  = pend_handle_q;
                out_data_d.from_periodic = pend_per_q;
                out_data_d.table_full    = 1'b0;
                out_data_d.last          = 1'b0;
              end
              pend_v_d      = 1'b1;
              pend_handle_d = (state_q == S_PR_ACT) ? pr_rd.handle : os_rd.handle;
              pend_per_d    = (state_q == S_PR_ACT);
              n_d           = n_q + 1'b1;
            end
          end
          if (state_q == S_OS_ACT) begin
            // Survivors move down to the compaction slot, keeping their order.
            if (!alu_fire) begin
              os_we = 1'b1;
              w_d   = w_q + 1'b1;
            end
            i_d = i_nxt;
            if (i_nxt == ICW'(os_used_q)) begin
              os_used_d = alu_fire ? w_q : OCW'(w_q + 1'b1);
              i_d       = '0;
              state_d   = S_PR_RD;
            end
          end else begin
            // Write back in place: new count, or the reload after a fire.
            pr_we = 1'b1;
            i_d   = i_nxt;
            if (i_nxt == ICW'(pr_used_q)) begin
              state_d = S_FLUSH;
            end
          end
        end
      end

      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d              = 1'b1;
          out_data_d.result_kind   = RES_FIRED;
          out_data_d.fired_handle  = pend_handle_q;
          out_data_d.from_periodic = pend_per_q;
          out_data_d.table_full    = 1'b0;
          out_data_d.last          = 1'b1;
          pend_v_d                 = 1'b0;
          state_d                  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      w_q         <= '0;
      os_used_q   <= '0;
      pr_used_q   <= '0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      w_q         <= w_d;
      os_used_q   <= os_used_d;
      pr_used_q   <= pr_used_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    item_q        <= item_d;
    pend_handle_q <= pend_handle_d;
    pend_per_q    <= pend_per_d;
    out_data_q    <= out_data_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_os_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    os_used_q <= OCW'(ONESHOT_SLOTS))
    else $error("one-shot fill count beyond table size");

  a_pr_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pr_used_q <= PCW'(PERIODIC_SLOTS))
    else $error("periodic fill count beyond table size");

  a_compact_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OS_ACT) |-> (ICW'(w_q) <= i_q))
    else $error("compaction slot ahead of scan slot");

  a_pend_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (n_q != '0))
    else $error("pending fire not counted");

  a_add_ack_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD && out_free) |=> (out_valid_q && out_data_q.last &&
                                        out_data_q.result_kind == RES_ADD_ACK))
    else $error("add acknowledge not loaded");
`endif

endmodule

// ===== src/tmrb_ram.sv =====
// Simple dual-port timer table storage: one write port, one registered read port.
// Depends on nothing; instantiated by the timer bank top level.
module tmrb_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 49,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tmrb_alu.sv =====
// Shared countdown unit: subtract the tick delta and flag a due timer.
// Depends on tmrb_pkg.
module tmrb_alu (
  input  tmrb_pkg::cnt_t rem_i,
  input  logic [15:0]    delta_i,
  output tmrb_pkg::cnt_t cnt_o,
  output logic           fire_o
);
  import tmrb_pkg::*;

  cnt_t cnt;

  // Counts stay within 33-bit signed range, so no overflow check.
  assign cnt    = rem_i - $signed({17'b0, delta_i});
  assign cnt_o  = cnt;
  assign fire_o = cnt[32] || (cnt == '0);

endmodule
